### rtl/wmd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmd_pkg
// Types, register indexes and fixed-point helpers for the momentum dump block.
// ----------------------------------------------------------------------------
package wmd_pkg;

	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	typedef enum logic [2:0] {
		REG_THRESHOLD = 3'd0,
		REG_PERIOD    = 3'd1,
		REG_LIMIT     = 3'd2,
		REG_GAIN_P    = 3'd3,
		REG_GAIN_I    = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic               func;
		logic signed [31:0] wheel_speed_0;
		logic signed [31:0] wheel_speed_1;
		logic signed [31:0] wheel_speed_2;
		logic signed [31:0] wheel_speed_3;
		logic [1:0]         coef_axis;
		logic [1:0]         coef_wheel;
		logic signed [31:0] coef_value;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] torque_x;
		logic signed [31:0] torque_y;
		logic signed [31:0] torque_z;
		logic               dumping;
	} result_t;

	typedef struct packed {
		logic [30:0] momentum_threshold;
		logic [30:0] control_period;
		logic [30:0] integral_limit;
		logic [30:0] gain_proportional;
		logic [30:0] gain_integral;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MOM,
		ST_MOM_WAIT,
		ST_SQ,
		ST_SQ_WAIT,
		ST_CMP,
		ST_CTRL,
		ST_CTRL_WAIT,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_COEF,
		OP_SQ,
		OP_THR,
		OP_STEP,
		OP_KH,
		OP_KI
	} op_t;

	// one multiplier operation in flight
	typedef struct packed {
		op_t        op;
		logic [1:0] k;
		logic       last;
	} tag_t;

	function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647) begin
			return 32'sh7fffffff;
		end else if (v < -66'sd2147483648) begin
			return 32'sh80000000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage
`default_nettype wire

### rtl/wmd_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmd_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module wmd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

### rtl/wmd_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wmd_core
// Sequencer and shared multiplier datapath: momentum, norm, PI update, torque.
// ----------------------------------------------------------------------------
module wmd_core #(
	parameter int NUM_WHEELS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire wmd_pkg::cfg_t                 cfg,
	input  wire wmd_pkg::cmd_t                 sample,
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	output wmd_pkg::result_t                   result,
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic                               coef_we,
	output logic [$clog2(3*NUM_WHEELS)-1:0]    coef_waddr,
	output logic [31:0]                        coef_wdata,
	output logic [$clog2(3*NUM_WHEELS)-1:0]    coef_raddr,
	input  wire logic [31:0]                   coef_rdata,
	output logic                               st_we,
	output logic [1:0]                         st_waddr,
	output logic [63:0]                        st_wdata,
	output logic [1:0]                         st_raddr,
	input  wire logic [63:0]                   st_rdata
);

	localparam int CAW = $clog2(3*NUM_WHEELS);
	localparam int WW  = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

	wmd_pkg::state_t state_q, state_d;
	wmd_pkg::tag_t   iss, tag_s1, tag_s2;

	logic [WW-1:0]   i_q, i_d, wheel_s1;
	logic [1:0]      k_q, k_d;
	logic [CAW-1:0]  addr_q, addr_d;
	logic [3:0]      cnt_q, cnt_d;
	logic            accept;
	logic            pipe_busy;

	logic signed [31:0] speed_q [NUM_WHEELS];
	logic signed [31:0] spd_in  [4];
	logic signed [31:0] h_q     [3];
	logic signed [31:0] inew_q  [3];
	logic signed [63:0] tq_q    [3];
	logic signed [31:0] torque_q[3];
	logic [2:0]         valid_q;
	logic               sval_s1;
	logic signed [43:0] acc_q;
	logic [63:0]        norm_q;
	logic [63:0]        thr2_q;
	logic               dumping_q;

	logic signed [32:0] a_s1, b_s1;
	logic signed [65:0] prod;
	logic signed [65:0] prod_s2;
	logic signed [31:0] prior_s1, integ_s1, integ_s2;
	logic [63:0]        st_rd;

	logic signed [65:0] term;
	logic signed [43:0] acc_sum;
	logic signed [65:0] stp;
	logic signed [41:0] ivec, lim_s, iclamp;
	logic signed [65:0] tsum, tneg;

	logic               load_out;
	wmd_pkg::result_t   result_q;

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != wmd_pkg::ST_IDLE);
	assign pipe_busy    = (tag_s1.op != wmd_pkg::OP_NONE) || (tag_s2.op != wmd_pkg::OP_NONE);

	// coefficient loads go straight to the table
	assign coef_we    = accept && (sample.func == wmd_pkg::FUNC_LOAD) &&
	                    (sample.coef_axis != 2'd3) && (32'(sample.coef_wheel) < NUM_WHEELS);
	assign coef_waddr = CAW'(32'(sample.coef_axis) * NUM_WHEELS + 32'(sample.coef_wheel));
	assign coef_wdata = sample.coef_value;
	assign coef_raddr = addr_q;
	assign st_raddr   = iss.k;

	assign spd_in[0] = sample.wheel_speed_0;
	assign spd_in[1] = sample.wheel_speed_1;
	assign spd_in[2] = sample.wheel_speed_2;
	assign spd_in[3] = sample.wheel_speed_3;

	// sequencer
	always_comb begin
		state_d  = state_q;
		i_d      = i_q;
		k_d      = k_q;
		addr_d   = addr_q;
		cnt_d    = cnt_q;
		iss      = '{op: wmd_pkg::OP_NONE, k: 2'd0, last: 1'b0};
		load_out = 1'b0;
		case (state_q)
			wmd_pkg::ST_IDLE: begin
				i_d    = '0;
				k_d    = '0;
				addr_d = '0;
				cnt_d  = '0;
				if (accept && sample.func == wmd_pkg::FUNC_SAMPLE) begin
					state_d = wmd_pkg::ST_MOM;
				end
			end
			wmd_pkg::ST_MOM: begin
				iss.op   = wmd_pkg::OP_COEF;
				iss.k    = k_q;
				iss.last = (i_q == WW'(NUM_WHEELS - 1));
				addr_d   = addr_q + CAW'(1);
				if (iss.last) begin
					i_d = '0;
					k_d = k_q + 2'd1;
					if (k_q == 2'd2) begin
						state_d = wmd_pkg::ST_MOM_WAIT;
					end
				end else begin
					i_d = i_q + WW'(1);
				end
			end
			wmd_pkg::ST_MOM_WAIT: begin
				if (!pipe_busy) begin
					state_d = wmd_pkg::ST_SQ;
				end
			end
			wmd_pkg::ST_SQ: begin
				iss.op = (cnt_q == 4'd3) ? wmd_pkg::OP_THR : wmd_pkg::OP_SQ;
				iss.k  = cnt_q[1:0];
				cnt_d  = cnt_q + 4'd1;
				if (cnt_q == 4'd3) begin
					cnt_d   = '0;
					state_d = wmd_pkg::ST_SQ_WAIT;
				end
			end
			wmd_pkg::ST_SQ_WAIT: begin
				if (!pipe_busy) begin
					state_d = wmd_pkg::ST_CMP;
				end
			end
			wmd_pkg::ST_CMP: begin
				state_d = (norm_q >= thr2_q) ? wmd_pkg::ST_CTRL : wmd_pkg::ST_DONE;
			end
			wmd_pkg::ST_CTRL: begin
				// integral steps, then K*h, then Ki*I once each I is written back
				if (cnt_q < 4'd3) begin
					iss.op = wmd_pkg::OP_STEP;
					iss.k  = cnt_q[1:0];
				end else if (cnt_q < 4'd6) begin
					iss.op = wmd_pkg::OP_KH;
					iss.k  = 2'(cnt_q - 4'd3);
				end else begin
					iss.op = wmd_pkg::OP_KI;
					iss.k  = 2'(cnt_q - 4'd6);
				end
				cnt_d = cnt_q + 4'd1;
				if (cnt_q == 4'd8) begin
					state_d = wmd_pkg::ST_CTRL_WAIT;
				end
			end
			wmd_pkg::ST_CTRL_WAIT: begin
				if (!pipe_busy) begin
					state_d = wmd_pkg::ST_DONE;
				end
			end
			wmd_pkg::ST_DONE: begin
				if (!result_valid || !result_stall) begin
					load_out = 1'b1;
					state_d  = wmd_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wmd_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= wmd_pkg::ST_IDLE;
			i_q     <= '0;
			k_q     <= '0;
			addr_q  <= '0;
			cnt_q   <= '0;
			tag_s1  <= '{op: wmd_pkg::OP_NONE, k: 2'd0, last: 1'b0};
			tag_s2  <= '{op: wmd_pkg::OP_NONE, k: 2'd0, last: 1'b0};
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			k_q     <= k_d;
			addr_q  <= addr_d;
			cnt_q   <= cnt_d;
			tag_s1  <= iss;
			tag_s2  <= tag_s1;
		end
	end

	// stage 1: operand select and multiply
	assign st_rd    = sval_s1 ? st_rdata : 64'd0;
	assign prior_s1 = st_rd[63:32];
	assign integ_s1 = st_rd[31:0];

	always_comb begin
		a_s1 = '0;
		b_s1 = '0;
		case (tag_s1.op)
			wmd_pkg::OP_COEF: begin
				a_s1 = 33'(signed'(coef_rdata));
				b_s1 = 33'(speed_q[wheel_s1]);
			end
			wmd_pkg::OP_SQ: begin
				a_s1 = 33'(h_q[tag_s1.k]);
				b_s1 = 33'(h_q[tag_s1.k]);
			end
			wmd_pkg::OP_THR: begin
				a_s1 = {2'b00, cfg.momentum_threshold};
				b_s1 = {2'b00, cfg.momentum_threshold};
			end
			wmd_pkg::OP_STEP: begin
				a_s1 = 33'(prior_s1) + 33'(h_q[tag_s1.k]);
				b_s1 = {2'b00, cfg.control_period};
			end
			wmd_pkg::OP_KH: begin
				a_s1 = 33'(h_q[tag_s1.k]);
				b_s1 = {2'b00, cfg.gain_proportional};
			end
			wmd_pkg::OP_KI: begin
				a_s1 = 33'(inew_q[tag_s1.k]);
				b_s1 = {2'b00, cfg.gain_integral};
			end
			default: begin
				a_s1 = '0;
				b_s1 = '0;
			end
		endcase
	end

	assign prod = 66'(a_s1) * 66'(b_s1);

	always_ff @(posedge clk) begin
		wheel_s1 <= i_q;
		sval_s1  <= valid_q[iss.k];
		prod_s2  <= prod;
		integ_s2 <= integ_s1;
	end

	// stage 2: consume products
	assign term    = prod_s2 >>> 24;
	assign acc_sum = acc_q + term[43:0];
	assign stp     = prod_s2 >>> 25;
	assign ivec    = stp[41:0] + 42'(integ_s2);
	assign lim_s   = {11'b0, cfg.integral_limit};
	assign tsum    = 66'(tq_q[tag_s2.k]) + prod_s2;
	assign tneg    = -tsum;

	always_comb begin
		if (ivec > lim_s) begin
			iclamp = lim_s;
		end else if (ivec < -lim_s) begin
			iclamp = -lim_s;
		end else begin
			iclamp = ivec;
		end
	end

	// write back prior momentum and new integral
	assign st_we    = (tag_s2.op == wmd_pkg::OP_STEP);
	assign st_waddr = tag_s2.k;
	assign st_wdata = {h_q[tag_s2.k], iclamp[31:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (state_q == wmd_pkg::ST_CMP && norm_q < thr2_q) begin
			valid_q <= '0;
		end else if (st_we) begin
			valid_q[tag_s2.k] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				speed_q[i] <= (i < 4) ? spd_in[i[1:0]] : 32'sd0;
			end
			acc_q  <= '0;
			norm_q <= '0;
		end
		case (tag_s2.op)
			wmd_pkg::OP_COEF: begin
				if (tag_s2.last) begin
					h_q[tag_s2.k] <= wmd_pkg::sat32(66'(acc_sum));
					acc_q         <= '0;
				end else begin
					acc_q <= acc_sum;
				end
			end
			wmd_pkg::OP_SQ: begin
				norm_q <= norm_q + prod_s2[63:0];
			end
			wmd_pkg::OP_THR: begin
				thr2_q <= prod_s2[63:0];
			end
			wmd_pkg::OP_STEP: begin
				inew_q[tag_s2.k] <= iclamp[31:0];
			end
			wmd_pkg::OP_KH: begin
				tq_q[tag_s2.k] <= prod_s2[63:0];
			end
			wmd_pkg::OP_KI: begin
				torque_q[tag_s2.k] <= wmd_pkg::sat32(tneg >>> 24);
			end
			default: begin
			end
		endcase
		if (state_q == wmd_pkg::ST_CMP) begin
			dumping_q <= (norm_q >= thr2_q);
			if (norm_q < thr2_q) begin
				for (int k = 0; k < 3; k++) begin
					torque_q[k] <= '0;
				end
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load_out) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			result_q.torque_x <= torque_q[0];
			result_q.torque_y <= torque_q[1];
			result_q.torque_z <= torque_q[2];
			result_q.dumping  <= dumping_q;
		end
	end

	assign result = result_q;

endmodule
`default_nettype wire

### rtl/wheel_momentum_dump_pi.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_momentum_dump_pi
// Reaction wheel momentum dumping, PI control law in fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   sample/sample_valid/sample_stall: input requests. func=1 loads one
//   coefficient into the 3 x NUM_WHEELS table in the accept cycle and gives
//   no result. func=0 is a wheel speed sample and gives one result.
//   result/result_valid/result_stall: torque request, held while stalled.
//   cfg_valid/cfg_ready/cfg_index/cfg_data: register writes, always ready;
//   write only while the block is idle.
// Sequencing: the single shared 33x33 multiplier runs momentum, norm,
//   threshold square, integral step and both gain products in turn; a
//   sample below the threshold skips the integral step and gain products.
//   One sample is worked at a time; the next request is taken in the cycle
//   after the result is loaded; a load is written in its accept cycle.
// A finished result waits in the output register; the next request may be
//   accepted meanwhile, but its result waits for the register to free up.
// Reset clears the integral and prior momentum (entry valid bits) and loads
//   the register defaults; the coefficient table is undefined until loaded.
// ----------------------------------------------------------------------------
module wheel_momentum_dump_pi #(
	parameter int NUM_WHEELS = 4
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire wmd_pkg::cmd_t     sample,
	input  wire logic              sample_valid,
	output logic                   sample_stall,
	output wmd_pkg::result_t       result,
	output logic                   result_valid,
	input  wire logic              result_stall,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [2:0]        cfg_index,
	input  wire logic [30:0]       cfg_data
);

	localparam int CAW = $clog2(3*NUM_WHEELS);

	wmd_pkg::cfg_t  cfg_q;
	logic           coef_we;
	logic [CAW-1:0] coef_waddr, coef_raddr;
	logic [31:0]    coef_wdata, coef_rdata;
	logic           st_we;
	logic [1:0]     st_waddr, st_raddr;
	logic [63:0]    st_wdata, st_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.momentum_threshold <= '0;
			cfg_q.control_period     <= '0;
			cfg_q.integral_limit     <= 31'h7fffffff;
			cfg_q.gain_proportional  <= '0;
			cfg_q.gain_integral      <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				wmd_pkg::REG_THRESHOLD: cfg_q.momentum_threshold <= cfg_data;
				wmd_pkg::REG_PERIOD:    cfg_q.control_period     <= cfg_data;
				wmd_pkg::REG_LIMIT:     cfg_q.integral_limit     <= cfg_data;
				wmd_pkg::REG_GAIN_P:    cfg_q.gain_proportional  <= cfg_data;
				wmd_pkg::REG_GAIN_I:    cfg_q.gain_integral      <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	wmd_ram #(
		.WIDTH(32),
		.DEPTH(3*NUM_WHEELS)
	) u_coef_ram (
		.clk  (clk),
		.we   (coef_we),
		.waddr(coef_waddr),
		.wdata(coef_wdata),
		.raddr(coef_raddr),
		.rdata(coef_rdata)
	);

	// {prior momentum, integral} per axis
	wmd_ram #(
		.WIDTH(64),
		.DEPTH(3)
	) u_state_ram (
		.clk  (clk),
		.we   (st_we),
		.waddr(st_waddr),
		.wdata(st_wdata),
		.raddr(st_raddr),
		.rdata(st_rdata)
	);

	wmd_core #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.sample      (sample),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.coef_we     (coef_we),
		.coef_waddr  (coef_waddr),
		.coef_wdata  (coef_wdata),
		.coef_raddr  (coef_raddr),
		.coef_rdata  (coef_rdata),
		.st_we       (st_we),
		.st_waddr    (st_waddr),
		.st_wdata    (st_wdata),
		.st_raddr    (st_raddr),
		.st_rdata    (st_rdata)
	);

endmodule
`default_nettype wire

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Momentum dump PI block: coefficient loads and wheel speed samples under
// several register settings, with random gaps on both sides and one long
// output hold-off. A behavioral predictor checks every torque result.
// ----------------------------------------------------------------------------
module tb;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES   = 60;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	wmd_pkg::cmd_t    sample = '0;
	logic             sample_valid = 1'b0;
	logic             sample_stall;
	wmd_pkg::result_t result;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [2:0]       cfg_index = '0;
	logic [30:0]      cfg_data = '0;

	wheel_momentum_dump_pi uut (
		.clk(clk), .arst_n(arst_n),
		.sample(sample), .sample_valid(sample_valid), .sample_stall(sample_stall),
		.result(result), .result_valid(result_valid), .result_stall(result_stall),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	// predictor state
	longint      coef_tbl [3][4];
	longint      integ [3];
	longint      prior_h [3];
	logic [30:0] reg_mirror [5];

	wmd_pkg::cmd_t    pending_cmds [$];
	wmd_pkg::result_t torque_expected [$];

	int  errors = 0;
	int  n_req = 0;
	int  n_loads = 0;
	int  n_res = 0;
	int  n_dump = 0;
	int  idle_cycles = 0;
	bit  calm = 1'b0;
	bit  taken = 1'b0;
	int  hold_left = 0;
	bit  hold_done = 1'b0;

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	task automatic predict_torque(input wmd_pkg::cmd_t c);
		longint spd [4];
		longint h [3];
		longint acc, stp, lim, t;
		longint unsigned norm2, thr2, mag;
		wmd_pkg::result_t r;
		if (c.func == wmd_pkg::FUNC_LOAD) begin
			if (c.coef_axis < 2'd3) coef_tbl[c.coef_axis][c.coef_wheel] = longint'(c.coef_value);
			return;
		end
		spd[0] = longint'(c.wheel_speed_0);
		spd[1] = longint'(c.wheel_speed_1);
		spd[2] = longint'(c.wheel_speed_2);
		spd[3] = longint'(c.wheel_speed_3);
		norm2 = 0;
		for (int k = 0; k < 3; k++) begin
			acc = 0;
			for (int i = 0; i < 4; i++) acc += (coef_tbl[k][i] * spd[i]) >>> 24;
			h[k] = clip32(acc);
			mag = (h[k] < 0) ? longint'(-h[k]) : h[k];
			norm2 += mag * mag;
		end
		thr2 = longint'(reg_mirror[wmd_pkg::REG_THRESHOLD]) *
			longint'(reg_mirror[wmd_pkg::REG_THRESHOLD]);
		r = '0;
		if (norm2 < thr2) begin
			for (int k = 0; k < 3; k++) begin
				integ[k] = 0;
				prior_h[k] = 0;
			end
		end else begin
			lim = longint'(reg_mirror[wmd_pkg::REG_LIMIT]);
			for (int k = 0; k < 3; k++) begin
				stp = ((prior_h[k] + h[k]) * longint'(reg_mirror[wmd_pkg::REG_PERIOD])) >>> 25;
				acc = integ[k] + stp;
				if (acc > lim) acc = lim;
				if (acc < -lim) acc = -lim;
				integ[k] = acc;
				prior_h[k] = h[k];
				t = clip32(-(longint'(reg_mirror[wmd_pkg::REG_GAIN_P]) * h[k]
					+ longint'(reg_mirror[wmd_pkg::REG_GAIN_I]) * acc) >>> 24);
				case (k)
					0: r.torque_x = t[31:0];
					1: r.torque_y = t[31:0];
					default: r.torque_z = t[31:0];
				endcase
			end
			r.dumping = 1'b1;
		end
		torque_expected.push_back(r);
	endtask

	// sender
	always @(negedge clk) begin
		if (arst_n && (!sample_valid || taken)) begin
			if (pending_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 23)) begin
				sample <= pending_cmds.pop_front();
				sample_valid <= 1'b1;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	// receiver, including one long hold-off once traffic is under way
	always @(negedge clk) begin
		if (hold_left > 0) begin
			result_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (!hold_done && n_req >= 200) begin
			hold_done <= 1'b1;
			hold_left <= 400;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < 23);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin
		wmd_pkg::result_t exp_r;
		taken = sample_valid && !sample_stall;
		if (taken) begin
			n_req++;
			if (sample.func == wmd_pkg::FUNC_LOAD) n_loads++;
			predict_torque(sample);
		end
		if (result_valid && !result_stall) begin
			n_res++;
			if (torque_expected.size() == 0) begin
				$error("torque request with no sample waiting");
				errors++;
			end else begin
				exp_r = torque_expected.pop_front();
				if (exp_r.dumping) n_dump++;
				if (result.torque_x !== exp_r.torque_x) begin
					$error("torque_x exp %h got %h", exp_r.torque_x, result.torque_x);
					errors++;
				end
				if (result.torque_y !== exp_r.torque_y) begin
					$error("torque_y exp %h got %h", exp_r.torque_y, result.torque_y);
					errors++;
				end
				if (result.torque_z !== exp_r.torque_z) begin
					$error("torque_z exp %h got %h", exp_r.torque_z, result.torque_z);
					errors++;
				end
				if (result.dumping !== exp_r.dumping) begin
					$error("dumping exp %b got %b", exp_r.dumping, result.dumping);
					errors++;
				end
			end
		end
		if (taken || (result_valid && !result_stall) || (cfg_valid && cfg_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("Verification failed");
			$finish;
		end
	end

	task automatic write_reg(input wmd_pkg::reg_idx_t idx, input logic [30:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		reg_mirror[idx] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_regs(input logic [30:0] thr, per, lim, kp, ki);
		write_reg(wmd_pkg::REG_THRESHOLD, thr);
		write_reg(wmd_pkg::REG_PERIOD, per);
		write_reg(wmd_pkg::REG_LIMIT, lim);
		write_reg(wmd_pkg::REG_GAIN_P, kp);
		write_reg(wmd_pkg::REG_GAIN_I, ki);
	endtask

	task automatic drain();
		while (pending_cmds.size() > 0 || sample_valid || torque_expected.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic wmd_pkg::cmd_t load_cmd(input logic [1:0] ax, wh,
		input logic [31:0] v);
		wmd_pkg::cmd_t c;
		c = wmd_pkg::cmd_t'(165'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
		c.func = wmd_pkg::FUNC_LOAD;
		c.coef_axis = ax;
		c.coef_wheel = wh;
		c.coef_value = v;
		return c;
	endfunction

	function automatic wmd_pkg::cmd_t speed_cmd(input logic [31:0] s0, s1, s2, s3);
		wmd_pkg::cmd_t c;
		c = wmd_pkg::cmd_t'(165'({$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom}));
		c.func = wmd_pkg::FUNC_SAMPLE;
		c.wheel_speed_0 = s0;
		c.wheel_speed_1 = s1;
		c.wheel_speed_2 = s2;
		c.wheel_speed_3 = s3;
		return c;
	endfunction

	// mostly modest magnitudes so the law does not just saturate
	function automatic logic [31:0] mixed_val(input int span);
		int unsigned m;
		if ($urandom_range(0, 3) == 0) return $urandom;
		m = $urandom_range(0, span);
		return $urandom_range(0, 1) ? -m : m;
	endfunction

	function automatic logic [30:0] rand_reg(input int span);
		if ($urandom_range(0, 4) == 0) return 31'($urandom);
		return 31'($urandom_range(0, span));
	endfunction

	task automatic random_burst(input int n);
		for (int j = 0; j < n; j++) begin
			if ($urandom_range(0, 99) < 20)
				pending_cmds.push_back(load_cmd(2'($urandom_range(0, 3)),
					2'($urandom_range(0, 3)), mixed_val(1 << 25)));
			else
				pending_cmds.push_back(speed_cmd(mixed_val(1 << 22), mixed_val(1 << 22),
					mixed_val(1 << 22), mixed_val(1 << 22)));
		end
	endtask

	initial begin
		for (int k = 0; k < 3; k++) begin
			integ[k] = 0;
			prior_h[k] = 0;
			for (int i = 0; i < 4; i++) coef_tbl[k][i] = 0;
		end
		reg_mirror[wmd_pkg::REG_THRESHOLD] = '0;
		reg_mirror[wmd_pkg::REG_PERIOD] = '0;
		reg_mirror[wmd_pkg::REG_LIMIT] = 31'h7fffffff;
		reg_mirror[wmd_pkg::REG_GAIN_P] = '0;
		reg_mirror[wmd_pkg::REG_GAIN_I] = '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: fill the whole table before any sample reads it
		set_regs(31'd0, 31'd1 << 23, 31'h7fffffff, 31'd1 << 24, 31'd1 << 22);
		for (int k = 0; k < 3; k++)
			for (int i = 0; i < 4; i++)
				pending_cmds.push_back(load_cmd(2'(k), 2'(i),
					(k == i) ? 32'h0100_0000 : 32'h0));
		pending_cmds.push_back(load_cmd(2'd3, 2'd1, 32'h7fffffff));   // ignored row
		pending_cmds.push_back(speed_cmd(32'h0001_0000, 32'h0002_0000, 32'hfffd_0000, 32'h0));
		pending_cmds.push_back(speed_cmd(32'h0, 32'h0, 32'h0, 32'h0));
		pending_cmds.push_back(speed_cmd(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000));
		pending_cmds.push_back(load_cmd(2'd0, 2'd3, 32'h7fffffff));
		pending_cmds.push_back(load_cmd(2'd1, 2'd3, 32'h80000000));
		pending_cmds.push_back(speed_cmd(32'h80000000, 32'h7fffffff, 32'h1, 32'h7fffffff));
		pending_cmds.push_back(speed_cmd(32'hffffffff, 32'hffffffff, 32'hffffffff, 32'h80000000));
		drain();

		// extreme registers; zero momentum stays below the threshold
		set_regs(31'h7fffffff, 31'h7fffffff, 31'd0, 31'h7fffffff, 31'h7fffffff);
		pending_cmds.push_back(speed_cmd(32'h0, 32'h0, 32'h0, 32'h0));
		pending_cmds.push_back(speed_cmd(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000));
		pending_cmds.push_back(speed_cmd(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff));
		drain();

		// random phases, one of them with no idling on either side
		for (int ph = 0; ph < 6; ph++) begin
			calm = (ph == 2);
			if (ph == 5)
				set_regs(31'd0, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
			else
				set_regs(rand_reg(1 << 22), rand_reg(1 << 25), rand_reg(1 << 26),
					rand_reg(1 << 25), rand_reg(1 << 25));
			random_burst(100);
			drain();
		end
		calm = 1'b0;

		$display("covered %0d requests (%0d coefficient loads), %0d torque results, %0d dumping",
			n_req, n_loads, n_res, n_dump);
		$display("across 8 register settings, with random gaps and one long output hold-off");
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
rtl/wmd_pkg.sv
rtl/wmd_ram.sv
rtl/wmd_core.sv
rtl/wheel_momentum_dump_pi.sv
tb/tb.sv
